// ===== rtl/dbfd_pkg.sv =====
// Shared types and constants for the double-buffered frame DMA.
// Holds the field widths, operation and result codes, and the controller/datapath structs.
// Depends on nothing.
package dbfd_pkg;

    // Fixed sizes of the block.
    localparam int BEATS_PER_BURST = 32;
    localparam int DATA_WIDTH      = 64;
    localparam int FLAG_DEPTH      = 8;

    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int BUS_W    = 64;
    localparam int IDX_W    = $clog2(BEATS_PER_BURST + 1);
    localparam int FCNT_W   = $clog2(FLAG_DEPTH + 1);
    localparam int FIDX_W   = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;
    localparam int CREDIT_W = 4;

    localparam logic [IDX_W-1:0]    LAST_BEAT  = IDX_W'(BEATS_PER_BURST - 1);
    localparam logic [ADDR_W-1:0]   BURST_STEP = ADDR_W'(BEATS_PER_BURST);
    localparam logic [FCNT_W-1:0]   FLAG_FULL  = FCNT_W'(FLAG_DEPTH);
    localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;
    localparam logic [BUS_W-1:0]    DATA_MASK  =
        (DATA_WIDTH >= BUS_W) ? '1 : BUS_W'((65'd1 << DATA_WIDTH) - 65'd1);

    // Input operation codes.
    localparam logic [OP_W-1:0] OP_STREAM     = 2'd0;
    localparam logic [OP_W-1:0] OP_READ_START = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_DATA  = 2'd2;

    // Result kind codes.
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STREAM  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_PAD  = 2'b10
    } t_state;

    // Datapath actions issued by the controller.
    typedef enum logic [2:0] {
        ACT_WRITE     = 3'd0,
        ACT_PAD       = 3'd1,
        ACT_READ_REQ  = 3'd2,
        ACT_READ_BEAT = 3'd3,
        ACT_REFUSE    = 3'd4
    } t_act;

    typedef struct packed {
        logic load;
        t_act act;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic writer_blocked;
        logic completes;
        logic needs_pad;
        logic pad_last;
        logic flag_full;
        logic flag_empty;
        logic read_active;
    } t_status;

endpackage

// ===== rtl/dbfd_ifs.sv =====
// Handshake channel interfaces of the frame DMA: input, result and configuration.
// Depends on dbfd_pkg for the field widths.
interface dbfd_in_if;
    logic                           valid;
    logic                           ready;
    logic [dbfd_pkg::OP_W-1:0]      operation;
    logic [dbfd_pkg::BUS_W-1:0]     data;
    logic                           frame_end;

    modport source (output valid, output operation, output data, output frame_end,
                    input ready);
    modport sink   (input valid, input operation, input data, input frame_end,
                    output ready);
endinterface

interface dbfd_out_if;
    logic                           valid;
    logic                           ready;
    logic [dbfd_pkg::KIND_W-1:0]    kind;
    logic [dbfd_pkg::ADDR_W-1:0]    address;
    logic [dbfd_pkg::BUS_W-1:0]     payload;
    logic                           stream_last;
    logic                           run_done;

    modport source (output valid, output kind, output address, output payload,
                    output stream_last, output run_done, input ready);
    modport sink   (input valid, input kind, input address, input payload,
                    input stream_last, input run_done, output ready);
endinterface

interface dbfd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dbfd_pkg::ADDR_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dbfd_ctrl.sv =====
// Controller of the frame DMA: accepts input words, checks them against the
// datapath status and sequences the zero padding of a short final burst.
// Depends on dbfd_pkg.
module dbfd_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [dbfd_pkg::OP_W-1:0] i_operation,
    output logic                      o_in_ready,
    input  dbfd_pkg::t_status         i_status,
    output dbfd_pkg::t_cmd            o_cmd
);

    dbfd_pkg::t_state r_state;
    dbfd_pkg::t_state n_state;
    logic             accept;

    // A new word enters only when idle and the output register can take a result.
    assign o_in_ready = (r_state == dbfd_pkg::ST_IDLE) && i_status.out_free;
    assign accept     = i_in_valid && o_in_ready;

    // Decide the datapath action and the next state.
    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.act  = dbfd_pkg::ACT_REFUSE;
        unique case (r_state)
            dbfd_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_operation)
                        dbfd_pkg::OP_STREAM: begin
                            if (!i_status.writer_blocked &&
                                !(i_status.completes && i_status.flag_full)) begin
                                o_cmd.act = dbfd_pkg::ACT_WRITE;
                                if (i_status.needs_pad) begin
                                    n_state = dbfd_pkg::ST_PAD;
                                end
                            end
                        end
                        dbfd_pkg::OP_READ_START: begin
                            if (!i_status.read_active && !i_status.flag_empty) begin
                                o_cmd.act = dbfd_pkg::ACT_READ_REQ;
                            end
                        end
                        dbfd_pkg::OP_READ_DATA: begin
                            if (i_status.read_active) begin
                                o_cmd.act = dbfd_pkg::ACT_READ_BEAT;
                            end
                        end
                        default: begin
                            o_cmd.act = dbfd_pkg::ACT_REFUSE;
                        end
                    endcase
                end
            end
            dbfd_pkg::ST_PAD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.act  = dbfd_pkg::ACT_PAD;
                    if (i_status.pad_last) begin
                        n_state = dbfd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = dbfd_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dbfd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/dbfd_dp.sv =====
// Datapath of the frame DMA: writer and reader state, burst flag queue,
// credit counter, configuration register and the registered result word.
// Depends on dbfd_pkg and the channel interfaces in dbfd_ifs.sv.
module dbfd_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [dbfd_pkg::BUS_W-1:0] i_data,
    input  logic                       i_frame_end,
    input  dbfd_pkg::t_cmd             i_cmd,
    output dbfd_pkg::t_status          o_status,
    dbfd_cfg_if.sink                   i_cfg,
    dbfd_out_if.source                 o_out
);

    // Configuration and writer state.
    logic [dbfd_pkg::ADDR_W-1:0]   r_second_base;
    logic [dbfd_pkg::ADDR_W-1:0]   r_write_base;
    logic [dbfd_pkg::IDX_W-1:0]    r_write_idx;
    logic                          r_credit_wait;
    logic                          r_writer_blocked;
    logic [dbfd_pkg::CREDIT_W-1:0] r_credits;

    // Flag queue: shifts toward entry zero on a pop.
    logic                          r_flags [dbfd_pkg::FLAG_DEPTH];
    logic [dbfd_pkg::FCNT_W-1:0]   r_flag_count;

    // Reader state.
    logic [dbfd_pkg::ADDR_W-1:0]   r_read_base;
    logic [dbfd_pkg::IDX_W-1:0]    r_read_idx;
    logic                          r_read_ends_frame;
    logic                          r_read_active;

    // Padding cursor.
    logic [dbfd_pkg::ADDR_W-1:0]   r_pad_addr;
    logic [dbfd_pkg::IDX_W-1:0]    r_pad_idx;

    // Output register.
    logic                          r_out_valid;
    logic [dbfd_pkg::KIND_W-1:0]   r_out_kind;
    logic [dbfd_pkg::ADDR_W-1:0]   r_out_addr;
    logic [dbfd_pkg::BUS_W-1:0]    r_out_payload;
    logic                          r_out_last;
    logic                          r_out_done;

    logic [dbfd_pkg::KIND_W-1:0]   n_out_kind;
    logic [dbfd_pkg::ADDR_W-1:0]   n_out_addr;
    logic [dbfd_pkg::BUS_W-1:0]    n_out_payload;
    logic                          n_out_last;
    logic                          n_out_done;

    logic [dbfd_pkg::ADDR_W-1:0]   write_addr;
    logic [dbfd_pkg::ADDR_W-1:0]   write_adv;
    logic [dbfd_pkg::ADDR_W-1:0]   read_adv;
    logic                          write_last_beat;
    logic                          read_last_beat;
    logic                          completes;

    assign i_cfg.ready = 1'b1;

    assign write_addr      = r_write_base + dbfd_pkg::ADDR_W'(r_write_idx);
    assign write_adv       = r_write_base + dbfd_pkg::BURST_STEP;
    assign read_adv        = r_read_base + dbfd_pkg::BURST_STEP;
    assign write_last_beat = (r_write_idx == dbfd_pkg::LAST_BEAT);
    assign read_last_beat  = (r_read_idx == dbfd_pkg::LAST_BEAT);
    assign completes       = i_frame_end || write_last_beat;

    // Status toward the controller.
    assign o_status.out_free       = !r_out_valid || o_out.ready;
    assign o_status.writer_blocked = r_writer_blocked;
    assign o_status.completes      = completes;
    assign o_status.needs_pad      = i_frame_end && !write_last_beat;
    assign o_status.pad_last       = (r_pad_idx == dbfd_pkg::LAST_BEAT);
    assign o_status.flag_full      = (r_flag_count == dbfd_pkg::FLAG_FULL);
    assign o_status.flag_empty     = (r_flag_count == '0);
    assign o_status.read_active    = r_read_active;

    // Result word for the current action.
    always_comb begin
        n_out_kind    = dbfd_pkg::KIND_REFUSED;
        n_out_addr    = '0;
        n_out_payload = '0;
        n_out_last    = 1'b0;
        n_out_done    = 1'b1;
        case (i_cmd.act)
            dbfd_pkg::ACT_WRITE: begin
                n_out_kind    = dbfd_pkg::KIND_WRITE;
                n_out_addr    = write_addr;
                n_out_payload = i_data & dbfd_pkg::DATA_MASK;
                n_out_done    = !(i_frame_end && !write_last_beat);
            end
            dbfd_pkg::ACT_PAD: begin
                n_out_kind = dbfd_pkg::KIND_WRITE;
                n_out_addr = r_pad_addr;
                n_out_done = (r_pad_idx == dbfd_pkg::LAST_BEAT);
            end
            dbfd_pkg::ACT_READ_REQ: begin
                n_out_kind = dbfd_pkg::KIND_READ;
                n_out_addr = r_read_base;
            end
            dbfd_pkg::ACT_READ_BEAT: begin
                n_out_kind    = dbfd_pkg::KIND_STREAM;
                n_out_payload = i_data & dbfd_pkg::DATA_MASK;
                n_out_last    = read_last_beat && r_read_ends_frame;
            end
            default: begin
                n_out_kind = dbfd_pkg::KIND_REFUSED;
            end
        endcase
    end

    // Output register: loads on a command, empties when the sink takes the word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_kind    <= n_out_kind;
            r_out_addr    <= n_out_addr;
            r_out_payload <= n_out_payload;
            r_out_last    <= n_out_last;
            r_out_done    <= n_out_done;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out_kind;
    assign o_out.address     = r_out_addr;
    assign o_out.payload     = r_out_payload;
    assign o_out.stream_last = r_out_last;
    assign o_out.run_done    = r_out_done;

    // Flag queue storage: push at the fill level, shift down on a pop.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_cmd.act == dbfd_pkg::ACT_WRITE) && completes) begin
            r_flags[r_flag_count[dbfd_pkg::FIDX_W-1:0]] <= i_frame_end;
        end else if (i_cmd.load && (i_cmd.act == dbfd_pkg::ACT_READ_REQ)) begin
            for (int i = 1; i < dbfd_pkg::FLAG_DEPTH; i++) begin
                r_flags[i-1] <= r_flags[i];
            end
        end
    end

    // Padding cursor, set just past each written beat and stepped by each padding beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_cmd.act == dbfd_pkg::ACT_WRITE)) begin
            r_pad_addr <= write_addr + dbfd_pkg::ADDR_W'(1);
            r_pad_idx  <= r_write_idx + dbfd_pkg::IDX_W'(1);
        end else if (i_cmd.load && (i_cmd.act == dbfd_pkg::ACT_PAD)) begin
            r_pad_addr <= r_pad_addr + dbfd_pkg::ADDR_W'(1);
            r_pad_idx  <= r_pad_idx + dbfd_pkg::IDX_W'(1);
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_base <= '0;
        end else if (i_cfg.valid) begin
            r_second_base <= i_cfg.data;
        end
    end

    // Writer, reader and credit state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_base      <= '0;
            r_write_idx       <= '0;
            r_credit_wait     <= 1'b0;
            r_writer_blocked  <= 1'b0;
            r_credits         <= '0;
            r_flag_count      <= '0;
            r_read_base       <= '0;
            r_read_idx        <= '0;
            r_read_ends_frame <= 1'b0;
            r_read_active     <= 1'b0;
        end else if (i_cmd.load) begin
            case (i_cmd.act)
                dbfd_pkg::ACT_WRITE: begin
                    if (completes) begin
                        r_flag_count <= r_flag_count + dbfd_pkg::FCNT_W'(1);
                        r_write_idx  <= '0;
                        if (i_frame_end) begin
                            // Switch buffers and settle the credit for this frame.
                            r_write_base <= (write_adv <= r_second_base) ? r_second_base : '0;
                            if (r_credit_wait) begin
                                if (r_credits != '0) begin
                                    r_credits <= r_credits - dbfd_pkg::CREDIT_W'(1);
                                end else begin
                                    r_writer_blocked <= 1'b1;
                                end
                            end else begin
                                r_credit_wait <= 1'b1;
                            end
                        end else begin
                            r_write_base <= write_adv;
                        end
                    end else begin
                        r_write_idx <= r_write_idx + dbfd_pkg::IDX_W'(1);
                    end
                end
                dbfd_pkg::ACT_READ_REQ: begin
                    r_read_ends_frame <= r_flags[0];
                    r_flag_count      <= r_flag_count - dbfd_pkg::FCNT_W'(1);
                    r_read_base       <= read_adv;
                    r_read_idx        <= '0;
                    r_read_active     <= 1'b1;
                end
                dbfd_pkg::ACT_READ_BEAT: begin
                    if (read_last_beat) begin
                        r_read_active <= 1'b0;
                        r_read_idx    <= '0;
                        if (r_read_ends_frame) begin
                            // A finished frame returns a credit or releases the writer.
                            if (r_writer_blocked) begin
                                r_writer_blocked <= 1'b0;
                            end else if (r_credits != dbfd_pkg::CREDIT_MAX) begin
                                r_credits <= r_credits + dbfd_pkg::CREDIT_W'(1);
                            end
                            r_read_base <= (r_read_base <= r_second_base) ?
                                           r_second_base : '0;
                        end
                    end else begin
                        r_read_idx <= r_read_idx + dbfd_pkg::IDX_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/double_buffered_frame_dma_top.sv =====
// Double-buffered frame DMA. Each accepted word yields its first result in the
// output register in the next cycle; one word is accepted per cycle while the sink keeps up.
// A stream word that ends a frame before the end of a burst is followed by one padding
// word per missing beat (up to BEATS_PER_BURST - 1), during which no input word is taken.
// Reset is synchronous, active low, and clears all control state; the queue starts empty.
module double_buffered_frame_dma_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbfd_in_if.sink     i_in,
    dbfd_cfg_if.sink    i_cfg,
    dbfd_out_if.source  o_out
);

    dbfd_pkg::t_cmd    cmd;
    dbfd_pkg::t_status status;
    logic              in_ready;

    assign i_in.ready = in_ready;

    // Sequencing and checks.
    dbfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_operation (i_in.operation),
        .o_in_ready  (in_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // State, queue and result register.
    dbfd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_in.data),
        .i_frame_end (i_in.frame_end),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg       (i_cfg),
        .o_out       (o_out)
    );

endmodule
